// File: hdl/srfp_pkg.sv
package srfp_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] DELIM_BYTE = 8'h26;
    localparam logic [7:0] CMD_SENSOR = 8'h1C;

    // Sensor ids
    localparam logic [7:0] ID_BODY          = 8'hE1;
    localparam logic [7:0] ID_BOOM          = 8'hE2;
    localparam logic [7:0] ID_ARM           = 8'hE3;
    localparam logic [7:0] ID_BUCKET        = 8'hE4;
    localparam logic [7:0] ID_SLEW          = 8'hE5;
    localparam logic [7:0] ID_BOOM_LENGTH   = 8'hEA;
    localparam logic [7:0] ID_ARM_LENGTH    = 8'hEB;
    localparam logic [7:0] ID_BUCKET_LENGTH = 8'hEC;
    localparam logic [7:0] ID_PROXIMITY     = 8'hD7;

    // Only payload bytes 0..18 are ever decoded
    localparam int READ_BYTES = 19;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_BAD_CMD  = 2'd2,
        ST_BAD_ID   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        KIND_BODY       = 4'd0,
        KIND_BOOM       = 4'd1,
        KIND_ARM        = 4'd2,
        KIND_BUCKET     = 4'd3,
        KIND_ROTATION   = 4'd4,
        KIND_BOOM_LEN   = 4'd5,
        KIND_ARM_LEN    = 4'd6,
        KIND_BUCKET_LEN = 4'd7,
        KIND_RADAR      = 4'd8,
        KIND_NONE       = 4'd9
    } kind_t;

    typedef logic [READ_BYTES-1:0][7:0] rd_bytes_t;

    typedef struct packed {
        logic fire;     // checksum byte consumed this cycle
        logic sum_ok;
    } chk_event_t;

    // Packed lowest field last, so status lands in bit 0
    typedef struct packed {
        logic [7:0]  rotation_way;
        logic [7:0]  rotation_ready;
        logic        radar_detected;
        logic [15:0] length_value;
        logic [31:0] word_d;
        logic [31:0] word_c;
        logic [31:0] word_b;
        logic [31:0] word_a;
        kind_t       sensor_kind;
        status_t     status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: hdl/srfp_parser.sv
module srfp_parser #(
    parameter int PAYLOAD_MAX = 30
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    output srfp_pkg::chk_event_t chk,
    output srfp_pkg::rd_bytes_t  rd_bytes
);

    localparam int IDX_W = $clog2(PAYLOAD_MAX);

    typedef enum logic [2:0] {
        HUNT    = 3'd0,
        LENGTH  = 3'd1,
        PAYLOAD = 3'd2,
        DELIM   = 3'd3,
        CHECK   = 3'd4
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [7:0]                sum_reg, sum_next;
    logic [7:0]                len_reg, len_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    srfp_pkg::rd_bytes_t       store_reg;
    logic                      store_wr;
    logic                      last_byte;

    // Frame done when idx+1 >= L-2
    assign last_byte = (10'(idx_reg) + 10'd3) >= 10'(len_reg);
    assign store_wr  = step && (phase_reg == PAYLOAD)
                       && (int'(idx_reg) < srfp_pkg::READ_BYTES);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        unique case (phase_reg)
            LENGTH:
            begin
                len_next   = rx_byte;
                sum_next   = sum_reg + rx_byte;
                idx_next   = '0;
                phase_next = PAYLOAD;
            end
            PAYLOAD:
            begin
                sum_next = sum_reg + rx_byte;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(PAYLOAD_MAX - 1))
                    phase_next = HUNT;      // payload index at PAYLOAD_MAX-1: drop frame
                else if (last_byte)
                    phase_next = DELIM;
            end
            DELIM:
            begin
                if (rx_byte == srfp_pkg::DELIM_BYTE)
                begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = CHECK;
                end
                else
                    phase_next = HUNT;
            end
            CHECK:
                phase_next = HUNT;
            default:
            begin
                phase_next = HUNT;
                if (rx_byte == srfp_pkg::SYNC_BYTE)
                begin
                    sum_next   = srfp_pkg::SYNC_BYTE;
                    phase_next = LENGTH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HUNT;
            sum_reg   <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            store_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            if (store_wr)
                store_reg[idx_reg[4:0]] <= rx_byte;
        end
    end

    assign chk.fire   = step && (phase_reg == CHECK);
    assign chk.sum_ok = (sum_reg == rx_byte);
    assign rd_bytes   = store_reg;

endmodule

// File: hdl/srfp_decode.sv
module srfp_decode (
    input  srfp_pkg::chk_event_t chk,
    input  srfp_pkg::rd_bytes_t  rd_bytes,
    output srfp_pkg::result_t    result
);

    srfp_pkg::kind_t kind;

    always_comb
    begin
        unique case (rd_bytes[2])
            srfp_pkg::ID_BODY:          kind = srfp_pkg::KIND_BODY;
            srfp_pkg::ID_BOOM:          kind = srfp_pkg::KIND_BOOM;
            srfp_pkg::ID_ARM:           kind = srfp_pkg::KIND_ARM;
            srfp_pkg::ID_BUCKET:        kind = srfp_pkg::KIND_BUCKET;
            srfp_pkg::ID_SLEW:          kind = srfp_pkg::KIND_ROTATION;
            srfp_pkg::ID_BOOM_LENGTH:   kind = srfp_pkg::KIND_BOOM_LEN;
            srfp_pkg::ID_ARM_LENGTH:    kind = srfp_pkg::KIND_ARM_LEN;
            srfp_pkg::ID_BUCKET_LENGTH: kind = srfp_pkg::KIND_BUCKET_LEN;
            srfp_pkg::ID_PROXIMITY:     kind = srfp_pkg::KIND_RADAR;
            default:                    kind = srfp_pkg::KIND_NONE;
        endcase
    end

    always_comb
    begin
        result             = '0;
        result.sensor_kind = srfp_pkg::KIND_NONE;
        if (!chk.sum_ok)
            result.status = srfp_pkg::ST_BAD_SUM;
        else if (rd_bytes[0] != srfp_pkg::CMD_SENSOR)
            result.status = srfp_pkg::ST_BAD_CMD;
        else if (kind == srfp_pkg::KIND_NONE)
            result.status = srfp_pkg::ST_BAD_ID;
        else
        begin
            result.status      = srfp_pkg::ST_OK;
            result.sensor_kind = kind;
            case (kind)
                srfp_pkg::KIND_BODY:
                begin
                    result.word_a = {rd_bytes[6], rd_bytes[5], rd_bytes[4], rd_bytes[3]};
                    result.word_b = {rd_bytes[10], rd_bytes[9], rd_bytes[8], rd_bytes[7]};
                    result.word_c = {rd_bytes[14], rd_bytes[13], rd_bytes[12], rd_bytes[11]};
                    result.word_d = {rd_bytes[18], rd_bytes[17], rd_bytes[16], rd_bytes[15]};
                end
                srfp_pkg::KIND_BOOM, srfp_pkg::KIND_ARM, srfp_pkg::KIND_BUCKET:
                    result.word_a = {rd_bytes[6], rd_bytes[5], rd_bytes[4], rd_bytes[3]};
                srfp_pkg::KIND_ROTATION:
                begin
                    result.word_a         = {rd_bytes[6], rd_bytes[5], rd_bytes[4],
                                             rd_bytes[3]};
                    result.rotation_ready = rd_bytes[7];
                    result.rotation_way   = rd_bytes[8];
                end
                srfp_pkg::KIND_BOOM_LEN, srfp_pkg::KIND_ARM_LEN,
                srfp_pkg::KIND_BUCKET_LEN:
                    result.length_value = {rd_bytes[4], rd_bytes[3]};
                srfp_pkg::KIND_RADAR:
                    result.radar_detected = (rd_bytes[3] != 8'd0);
                default:
                    result.sensor_kind = srfp_pkg::KIND_NONE;
            endcase
        end
    end

endmodule

// File: hdl/sensor_reply_frame_parser.sv
// Channel   Dir  Width  Item
// s_axis    in   8      rx_byte, one received serial byte
// m_axis    out  168    one decoded reply result, only on a frame's checksum byte
//
// Each byte passes through the input register, then the parse step and decode into
// the output register. One byte per cycle while the output is not stalled.
// Reset clears the parse state and the payload store to zero.
// A stalled output holds the result; the input register drains any byte, also one
// that causes no result, only while the output register is free or being taken.
module sensor_reply_frame_parser #(
    parameter int PAYLOAD_MAX = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [5:2] sensor_kind, [37:6] word_a, [69:38] word_b,
    // [101:70] word_c, [133:102] word_d, [149:134] length_value,
    // [150] radar_detected, [158:151] rotation_ready, [166:159] rotation_way
    output logic [srfp_pkg::OUT_W-1:0]    m_axis_tdata
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    srfp_pkg::result_t     out_data_reg;
    logic                  advance;
    srfp_pkg::chk_event_t  chk;
    srfp_pkg::rd_bytes_t   rd_bytes;
    srfp_pkg::result_t     result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    srfp_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .rx_byte  (in_byte_reg),
        .chk      (chk),
        .rd_bytes (rd_bytes)
    );

    srfp_decode u_decode (
        .chk      (chk),
        .rd_bytes (rd_bytes),
        .result   (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
            out_valid_next = 1'b0;
        if (chk.fire)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (chk.fire)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(srfp_pkg::OUT_W - srfp_pkg::RESULT_W){1'b0}}, out_data_reg};

    // A failed frame reports no kind and no data
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_data_reg.status != srfp_pkg::ST_OK)
        |-> (out_data_reg.sensor_kind == srfp_pkg::KIND_NONE)
            && (out_data_reg.word_a == 32'd0) && (out_data_reg.length_value == 16'd0)
            && !out_data_reg.radar_detected)
        else $error("failed frame carries data");

    // A good frame always names a known kind
    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_data_reg.status == srfp_pkg::ST_OK)
        |-> (out_data_reg.sensor_kind != srfp_pkg::KIND_NONE))
        else $error("good frame without kind");

    // A new result needs a byte that was waiting in the input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg))
        else $error("result without an item");

    // The output register is never overwritten while stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !chk.fire)
        else $error("result overrun");

endmodule
